@@ rtl/rotid_pkg.sv @@
// Shared constants, types and command/status structs of the rotating ID allocator.
package rotid_pkg;

  // Identifier space and field widths
  localparam int ID_BITS  = 10;
  localparam int FIELD_W  = 10;
  localparam int STATUS_W = 2;

  // Bitmap organization: the in-use map is kept as rows of WORD_W bits
  localparam int WORD_LG  = (ID_BITS < 6) ? ID_BITS - 1 : 5;
  localparam int WORD_W   = 1 << WORD_LG;
  localparam int ROW_LG   = ID_BITS - WORD_LG;
  localparam int ROWS     = 1 << ROW_LG;
  localparam int VISIT_W  = ROW_LG + 1;

  typedef logic [ID_BITS-1:0]  id_t;
  typedef logic [FIELD_W-1:0]  field_t;
  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [WORD_LG-1:0]  off_t;
  typedef logic [ROW_LG-1:0]   row_t;
  typedef logic [VISIT_W-1:0]  visit_t;

  typedef enum logic {
    ACT_ALLOC   = 1'b0,
    ACT_RECYCLE = 1'b1
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED = 2'd0,
    ST_FULL      = 2'd1,
    ST_RELEASED  = 2'd2,
    ST_IGNORED   = 2'd3
  } status_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear;  // write one zero row of the bitmap
    logic start;  // capture the accepted item
    logic read;   // read the current bitmap row
    logic eval;   // evaluate the row read last cycle
    logic load;   // move the result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clear_last;  // last bitmap row is being cleared
    logic eval_done;   // item finished in this evaluation
    logic out_free;    // output register can take a result
  } dp_stat_t;

endpackage

@@ rtl/rotid_if.sv @@
// Request and response channel interfaces of the rotating ID allocator.
interface rotid_req_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [rotid_pkg::FIELD_W-1:0] release_id;

  modport source (output valid, action, release_id, input ready);
  modport sink   (input valid, action, release_id, output ready);
endinterface

interface rotid_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [rotid_pkg::FIELD_W-1:0]  granted_id;
  logic [rotid_pkg::STATUS_W-1:0] status;

  modport source (output valid, granted_id, status, input ready);
  modport sink   (input valid, granted_id, status, output ready);
endinterface

@@ rtl/rotid_ctrl.sv @@
// Controller state machine: clearing sweep, item capture, row scan and result hand-off.
module rotid_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rotid_pkg::dp_stat_t  stat_i,
  output rotid_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_EVAL  = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Accept only while idle
  assign in_ready_o = (state_q == S_IDLE);

  // Decode commands from the current state
  always_comb begin
    cmd_o       = '0;
    cmd_o.clear = (state_q == S_CLEAR);
    cmd_o.start = (state_q == S_IDLE) && in_valid_i;
    cmd_o.read  = (state_q == S_READ);
    cmd_o.eval  = (state_q == S_EVAL);
    cmd_o.load  = (state_q == S_DONE) && stat_i.out_free;
  end

  // Advance the state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (stat_i.clear_last) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_READ;
      S_READ:  state_d = S_EVAL;
      S_EVAL:  state_d = stat_i.eval_done ? S_DONE : S_READ;
      S_DONE:  if (stat_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // An unfinished scan always goes back for the next row
  a_scan_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL && !stat_i.eval_done) |=> (state_q == S_READ))
    else $error("scan did not continue with a row read");

  // Nothing is accepted before the clearing sweep ends
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR && !stat_i.clear_last) |=> !in_ready_o)
    else $error("ready raised during clearing sweep");

endmodule

@@ rtl/rotid_dp.sv @@
// Datapath: in-use bitmap RAM, rover, row scan with priority encoding, output register.
module rotid_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rotid_pkg::ctrl_cmd_t          cmd_i,
  output rotid_pkg::dp_stat_t           stat_o,
  input  logic                          action_i,
  input  rotid_pkg::field_t             release_id_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output rotid_pkg::field_t             granted_id_o,
  output logic [rotid_pkg::STATUS_W-1:0] status_o
);

  // Bitmap storage, one row per address
  rotid_pkg::word_t mem [rotid_pkg::ROWS];
  rotid_pkg::word_t rd_q;

  rotid_pkg::row_t    clr_row_q;
  rotid_pkg::action_e act_q;
  rotid_pkg::id_t     id_q;
  logic               oob_q;
  rotid_pkg::row_t    row_q;
  logic               first_q;
  rotid_pkg::visit_t  visit_q;
  rotid_pkg::id_t     rover_q;

  rotid_pkg::id_t     res_id_q;
  rotid_pkg::status_e res_st_q;
  logic               out_valid_q;
  rotid_pkg::id_t     out_id_q;
  rotid_pkg::status_e out_st_q;

  rotid_pkg::id_t     rel_id;
  rotid_pkg::off_t    off;
  rotid_pkg::word_t   busy;
  logic               found;
  rotid_pkg::off_t    pos;
  rotid_pkg::id_t     grant;
  logic               last_visit;
  logic               rel_hit;

  logic               we;
  rotid_pkg::row_t    waddr;
  rotid_pkg::word_t   wdata;

  assign rel_id = rotid_pkg::id_t'(release_id_i);
  assign off    = id_q[rotid_pkg::WORD_LG-1:0];

  // Mark bits that cannot be granted: below the rover on the first row, and ID zero
  always_comb begin
    busy = rd_q;
    if (first_q) begin
      busy = busy | ((rotid_pkg::word_t'(1) << off) - rotid_pkg::word_t'(1));
    end
    if (row_q == '0) begin
      busy[0] = 1'b1;
    end
  end

  // Find the lowest free bit
  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int i = rotid_pkg::WORD_W - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        found = 1'b1;
        pos   = rotid_pkg::off_t'(i);
      end
    end
  end

  assign grant      = {row_q, pos};
  assign last_visit = (visit_q == rotid_pkg::visit_t'(rotid_pkg::ROWS));
  assign rel_hit    = !oob_q && rd_q[off];

  // Status to the controller
  assign stat_o.clear_last = (clr_row_q == '1);
  assign stat_o.eval_done  = (act_q == rotid_pkg::ACT_RECYCLE) || found || last_visit;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  // Select the single bitmap write
  always_comb begin
    we    = 1'b0;
    waddr = row_q;
    wdata = rd_q;
    if (cmd_i.clear) begin
      we    = 1'b1;
      waddr = clr_row_q;
      wdata = '0;
    end else if (cmd_i.eval) begin
      if (act_q == rotid_pkg::ACT_ALLOC) begin
        we          = found;
        wdata[pos]  = 1'b1;
      end else begin
        we          = rel_hit;
        wdata[off]  = 1'b0;
      end
    end
  end

  // Bitmap RAM: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd_i.read) begin
      rd_q <= mem[row_q];
    end
  end

  // Clearing sweep row counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_row_q <= '0;
    end else if (cmd_i.clear) begin
      clr_row_q <= clr_row_q + rotid_pkg::row_t'(1);
    end
  end

  // Capture the item, then step through rows
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      act_q   <= rotid_pkg::action_e'(action_i);
      oob_q   <= ((release_id_i >> rotid_pkg::ID_BITS) != '0);
      first_q <= 1'b1;
      visit_q <= '0;
      if (rotid_pkg::action_e'(action_i) == rotid_pkg::ACT_ALLOC) begin
        id_q  <= rover_q;
        row_q <= rover_q[rotid_pkg::ID_BITS-1:rotid_pkg::WORD_LG];
      end else begin
        id_q  <= rel_id;
        row_q <= rel_id[rotid_pkg::ID_BITS-1:rotid_pkg::WORD_LG];
      end
    end else if (cmd_i.eval && !stat_o.eval_done) begin
      row_q   <= row_q + rotid_pkg::row_t'(1);
      first_q <= 1'b0;
      visit_q <= visit_q + rotid_pkg::visit_t'(1);
    end
  end

  // Hold the result of the evaluation
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval && stat_o.eval_done) begin
      if (act_q == rotid_pkg::ACT_RECYCLE) begin
        res_id_q <= '0;
        res_st_q <= rel_hit ? rotid_pkg::ST_RELEASED : rotid_pkg::ST_IGNORED;
      end else if (found) begin
        res_id_q <= grant;
        res_st_q <= rotid_pkg::ST_ALLOCATED;
      end else begin
        res_id_q <= '0;
        res_st_q <= rotid_pkg::ST_FULL;
      end
    end
  end

  // Move the rover one past each granted ID
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rover_q <= rotid_pkg::id_t'(1);
    end else if (cmd_i.eval && act_q == rotid_pkg::ACT_ALLOC && found) begin
      rover_q <= grant + rotid_pkg::id_t'(1);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_id_q <= res_id_q;
      out_st_q <= res_st_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign granted_id_o = rotid_pkg::field_t'(out_id_q);
  assign status_o     = out_st_q;

  // A granted ID is never zero
  a_grant_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.eval && act_q == rotid_pkg::ACT_ALLOC && found) |-> (grant != '0))
    else $error("ID zero granted");

  // The granted bit was free in the row read
  a_grant_was_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.eval && act_q == rotid_pkg::ACT_ALLOC && found) |-> !rd_q[pos])
    else $error("granted ID already in use");

  // The scan never goes past one full lap plus the start row
  a_visit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.eval |-> (visit_q <= rotid_pkg::visit_t'(rotid_pkg::ROWS)))
    else $error("scan ran past the whole bitmap");

  // Only an allocation result carries an ID
  a_id_only_on_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_st_q != rotid_pkg::ST_ALLOCATED) |-> (out_id_q == '0))
    else $error("nonzero ID on a non-allocation result");

endmodule

@@ rtl/rotating_id_allocator_top.sv @@
// Top level of the rotating ID allocator: controller, datapath and channel wiring.
// Each request item either allocates the next free nonzero ID at or after the rover
// (searching forward with wraparound) or recycles release_id; one response item comes
// back for each request. The in-use bitmap sits in a RAM of 32-bit rows read one row
// per visit: an allocate reads and evaluates the rover's row, then each further row in
// turn until a free ID is found or the whole space has been scanned, when the status
// is full. A recycle reads and evaluates the row addressed by release_id. One item
// is in work at a time; the response waits in an output register, and the next
// request is accepted while it is still held. After reset a clearing sweep writes one
// bitmap row per cycle (32 rows at ID_BITS = 10) with ready low.
module rotating_id_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  rotid_req_if.sink   req_i,
  rotid_rsp_if.source rsp_o
);

  rotid_pkg::ctrl_cmd_t cmd;
  rotid_pkg::dp_stat_t  stat;
  logic                 in_ready;

  rotid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rotid_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .action_i     (req_i.action),
    .release_id_i (req_i.release_id),
    .out_ready_i  (rsp_o.ready),
    .out_valid_o  (rsp_o.valid),
    .granted_id_o (rsp_o.granted_id),
    .status_o     (rsp_o.status)
  );

  assign req_i.ready = in_ready;

endmodule
